@@ hw/rtl/ppi_pkg.sv @@
// ----------------------------------------------------------------------------
// ppi_pkg
// Shared types, codes and constants of the particle pool integrator.
// ----------------------------------------------------------------------------
`default_nettype none

package ppi_pkg;

  localparam int POOL_SLOTS = 64;
  localparam int FRAC_BITS  = 16;

  localparam int SLOT_W     = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int ALPHA_BITS = FRAC_BITS + 1;
  localparam int DIV_W      = $clog2(FRAC_BITS + 1);

  localparam logic [31:0] Q_ONE       = 32'(64'd1 << FRAC_BITS);
  localparam logic [31:0] SPLASH_Y    = 32'(((64'd1 << FRAC_BITS) * 5 + 50) / 100);
  localparam logic [31:0] SPLASH_LIFE = 32'(((64'd1 << FRAC_BITS) * 2 + 5) / 10);

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(POOL_SLOTS - 1);
  localparam logic [DIV_W-1:0]  LAST_DIV  = DIV_W'(FRAC_BITS - 1);

  typedef enum logic [1:0] {
    CMD_SPAWN = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    RES_DONE = 2'd0,
    RES_FULL = 2'd1,
    RES_READ = 2'd2
  } res_t;

  localparam logic [1:0] KIND_RAIN   = 2'd2;
  localparam logic [1:0] KIND_SPLASH = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_TK_CHECK, S_TK_LOAD, S_TK_MUL, S_TK_APPLY, S_TK_AGE,
    S_TK_FADE, S_TK_DIV, S_TK_WRITE, S_TK_NEXT, S_RD_REQ, S_RD_DATA, S_OUT
  } state_t;

  typedef enum logic [2:0] {
    ST_GRAV, ST_DRAG, ST_VX, ST_VY, ST_VZ, ST_PX, ST_PY, ST_PZ
  } step_t;

  typedef enum logic [1:0] {
    WS_SPAWN, WS_WORK, WS_SPLASH
  } wsrc_t;

  typedef struct packed {
    logic signed [31:0]    pos_x;
    logic signed [31:0]    pos_y;
    logic signed [31:0]    pos_z;
    logic signed [31:0]    vel_x;
    logic signed [31:0]    vel_y;
    logic signed [31:0]    vel_z;
    logic [31:0]           age;
    logic [31:0]           life;
    logic signed [31:0]    grav;
    logic [31:0]           drag;
    logic [1:0]            kind;
    logic [ALPHA_BITS-1:0] alpha;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  // controller to datapath
  typedef struct packed {
    logic              capture;
    logic [SLOT_W-1:0] addr;
    logic              use_arg;
    logic              ram_we;
    wsrc_t             wsrc;
    logic              act_set;
    logic              act_upd;
    logic              load_work;
    logic              mul_en;
    logic              apply_en;
    step_t             step;
    logic              age_en;
    logic              div_start;
    logic              div_step;
    logic              rd_capture;
    logic              res_set;
    res_t              res_code;
  } ppi_cmd_t;

  // datapath to controller
  typedef struct packed {
    cmd_t in_cmd;
    logic arg_ok;
    logic act;
    logic age_ge;
    logic splash;
  } ppi_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/ppi_ram.sv @@
// ----------------------------------------------------------------------------
// ppi_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ppi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [AW-1:0]         waddr,
  input  wire logic [WIDTH-1:0]      wdata,
  input  wire logic [AW-1:0]         raddr,
  output logic      [WIDTH-1:0]      rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hw/rtl/ppi_ctrl.sv @@
// ----------------------------------------------------------------------------
// ppi_ctrl
// Sequencer for spawn, tick walk, splash placement and slot read.
// ----------------------------------------------------------------------------
`default_nettype none

module ppi_ctrl import ppi_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  wire logic      out_stall,
  input  wire ppi_stat_t st,
  output ppi_cmd_t       cmd
);
  state_t            state, state_next;
  logic [SLOT_W-1:0] slot_idx, slot_idx_next;
  logic [SLOT_W-1:0] scan_idx, scan_idx_next;
  logic [DIV_W-1:0]  div_cnt, div_cnt_next;
  step_t             step, step_next;
  logic              splash_mode, splash_mode_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      slot_idx    <= '0;
      scan_idx    <= '0;
      div_cnt     <= '0;
      step        <= ST_GRAV;
      splash_mode <= 1'b0;
    end else begin
      state       <= state_next;
      slot_idx    <= slot_idx_next;
      scan_idx    <= scan_idx_next;
      div_cnt     <= div_cnt_next;
      step        <= step_next;
      splash_mode <= splash_mode_next;
    end
  end

  always_comb begin
    state_next       = state;
    slot_idx_next    = slot_idx;
    scan_idx_next    = scan_idx;
    div_cnt_next     = div_cnt;
    step_next        = step;
    splash_mode_next = splash_mode;
    in_stall         = 1'b1;
    out_valid        = 1'b0;
    cmd              = '0;
    cmd.addr         = slot_idx;
    cmd.step         = step;
    cmd.wsrc         = WS_WORK;
    cmd.res_code     = RES_DONE;

    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          case (st.in_cmd)
            CMD_SPAWN: begin
              scan_idx_next    = '0;
              splash_mode_next = 1'b0;
              state_next       = S_SCAN;
            end
            CMD_TICK: begin
              slot_idx_next = '0;
              state_next    = S_TK_CHECK;
            end
            CMD_READ: state_next = S_RD_REQ;
            default: begin
              cmd.res_set = 1'b1;
              state_next  = S_OUT;
            end
          endcase
        end
      end

      S_SCAN: begin
        cmd.addr = scan_idx;
        if (!st.act) begin
          cmd.ram_we  = 1'b1;
          cmd.act_set = 1'b1;
          cmd.wsrc    = splash_mode ? WS_SPLASH : WS_SPAWN;
          if (splash_mode) begin
            state_next = S_TK_NEXT;
          end else begin
            cmd.res_set = 1'b1;
            state_next  = S_OUT;
          end
        end else if (scan_idx == LAST_SLOT) begin
          if (splash_mode) begin
            state_next = S_TK_NEXT;
          end else begin
            cmd.res_set  = 1'b1;
            cmd.res_code = RES_FULL;
            state_next   = S_OUT;
          end
        end else begin
          scan_idx_next = scan_idx + 1'b1;
        end
      end

      S_TK_CHECK: state_next = st.act ? S_TK_LOAD : S_TK_NEXT;

      S_TK_LOAD: begin
        cmd.load_work = 1'b1;
        step_next     = ST_GRAV;
        state_next    = S_TK_MUL;
      end

      S_TK_MUL: begin
        cmd.mul_en = 1'b1;
        state_next = S_TK_APPLY;
      end

      S_TK_APPLY: begin
        cmd.apply_en = 1'b1;
        if (step == ST_PZ) begin
          state_next = S_TK_AGE;
        end else begin
          step_next  = step_t'(step + 3'd1);
          state_next = S_TK_MUL;
        end
      end

      S_TK_AGE: begin
        cmd.age_en = 1'b1;
        state_next = S_TK_FADE;
      end

      S_TK_FADE: begin
        if (st.age_ge) begin
          state_next = S_TK_WRITE;
        end else begin
          cmd.div_start = 1'b1;
          div_cnt_next  = '0;
          state_next    = S_TK_DIV;
        end
      end

      S_TK_DIV: begin
        cmd.div_step = 1'b1;
        if (div_cnt == LAST_DIV) begin
          state_next = S_TK_WRITE;
        end else begin
          div_cnt_next = div_cnt + 1'b1;
        end
      end

      S_TK_WRITE: begin
        cmd.ram_we  = 1'b1;
        cmd.act_upd = 1'b1;
        if (st.splash) begin
          scan_idx_next    = '0;
          splash_mode_next = 1'b1;
          state_next       = S_SCAN;
        end else begin
          state_next = S_TK_NEXT;
        end
      end

      S_TK_NEXT: begin
        if (slot_idx == LAST_SLOT) begin
          cmd.res_set = 1'b1;
          state_next  = S_OUT;
        end else begin
          slot_idx_next = slot_idx + 1'b1;
          state_next    = S_TK_CHECK;
        end
      end

      S_RD_REQ: begin
        cmd.use_arg = 1'b1;
        if (st.arg_ok) begin
          state_next = S_RD_DATA;
        end else begin
          cmd.res_set = 1'b1;
          state_next  = S_OUT;
        end
      end

      S_RD_DATA: begin
        cmd.use_arg    = 1'b1;
        cmd.rd_capture = 1'b1;
        state_next     = S_OUT;
      end

      S_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) state_next = S_IDLE;
      end

      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/ppi_dp.sv @@
// ----------------------------------------------------------------------------
// ppi_dp
// Slot store, active bits, shared multiplier, alpha divider, result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module ppi_dp import ppi_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ppi_cmd_t           cmd,
  output ppi_stat_t               st,
  input  wire logic [1:0]         command,
  input  wire logic signed [31:0] pos_x,
  input  wire logic signed [31:0] pos_y,
  input  wire logic signed [31:0] pos_z,
  input  wire logic signed [31:0] vel_x,
  input  wire logic signed [31:0] vel_y,
  input  wire logic signed [31:0] vel_z,
  input  wire logic [30:0]        lifetime,
  input  wire logic [1:0]         kind,
  input  wire logic signed [31:0] gravity,
  input  wire logic [30:0]        friction,
  input  wire logic [30:0]        argument,
  output logic [1:0]              status,
  output logic                    slot_is_active,
  output logic signed [31:0]      out_x,
  output logic signed [31:0]      out_y,
  output logic signed [31:0]      out_z,
  output logic [16:0]             out_alpha,
  output logic [1:0]              out_kind
);
  localparam logic signed [65:0] MAX32 = 66'sd2147483647;
  localparam logic signed [65:0] MIN32 = -66'sd2147483648;

  function automatic logic [31:0] sat32(input logic signed [65:0] v);
    logic [31:0] r;
    if (v > MAX32)      r = 32'h7FFF_FFFF;
    else if (v < MIN32) r = 32'h8000_0000;
    else                r = v[31:0];
    return r;
  endfunction

  // latched request
  rec_t               spawn_rec;
  logic [30:0]        dt;

  rec_t               w;
  rec_t               rdata;
  rec_t               wdata;
  logic [31:0]        f;
  logic signed [65:0] prod;
  logic signed [65:0] q;
  logic [32:0]        rem;
  logic [FRAC_BITS-1:0] quo;
  logic [POOL_SLOTS-1:0] active;

  logic [SLOT_W-1:0]  addr;
  logic signed [32:0] mul_a;
  logic [31:0]        mul_b;
  logic [32:0]        age_sum;
  logic [33:0]        rem_sh;
  logic               kill;
  logic [ALPHA_BITS-1:0] alpha_new;

  assign addr = cmd.use_arg ? dt[SLOT_W-1:0] : cmd.addr;
  assign q    = prod >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      dt              <= argument;
      spawn_rec.pos_x <= pos_x;
      spawn_rec.pos_y <= pos_y;
      spawn_rec.pos_z <= pos_z;
      spawn_rec.vel_x <= vel_x;
      spawn_rec.vel_y <= vel_y;
      spawn_rec.vel_z <= vel_z;
      spawn_rec.age   <= '0;
      spawn_rec.life  <= {1'b0, lifetime};
      spawn_rec.grav  <= gravity;
      spawn_rec.drag  <= {1'b0, friction};
      spawn_rec.kind  <= kind;
      spawn_rec.alpha <= ALPHA_BITS'(Q_ONE);
    end
  end

  // slot store
  always_comb begin
    case (cmd.wsrc)
      WS_SPAWN: wdata = spawn_rec;
      WS_SPLASH: begin
        wdata       = '0;
        wdata.pos_x = w.pos_x;
        wdata.pos_y = SPLASH_Y;
        wdata.pos_z = w.pos_z;
        wdata.life  = SPLASH_LIFE;
        wdata.kind  = KIND_SPLASH;
        wdata.alpha = ALPHA_BITS'(Q_ONE);
      end
      default: begin
        wdata       = w;
        wdata.alpha = alpha_new;
      end
    endcase
  end

  ppi_ram #(.WIDTH(REC_W), .DEPTH(POOL_SLOTS)) u_store (
    .clk   (clk),
    .we    (cmd.ram_we),
    .waddr (addr),
    .wdata (wdata),
    .raddr (addr),
    .rdata (rdata)
  );

  assign kill = st.age_ge || st.splash;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
    end else if (cmd.act_set) begin
      active[addr] <= 1'b1;
    end else if (cmd.act_upd) begin
      active[addr] <= !kill;
    end
  end

  // shared multiplier operand select
  always_comb begin
    case (cmd.step)
      ST_GRAV: begin mul_a = 33'(w.grav);      mul_b = {1'b0, dt}; end
      ST_DRAG: begin mul_a = {1'b0, w.drag};   mul_b = {1'b0, dt}; end
      ST_VX:   begin mul_a = 33'(w.vel_x);     mul_b = f;          end
      ST_VY:   begin mul_a = 33'(w.vel_y);     mul_b = f;          end
      ST_VZ:   begin mul_a = 33'(w.vel_z);     mul_b = f;          end
      ST_PX:   begin mul_a = 33'(w.vel_x);     mul_b = {1'b0, dt}; end
      ST_PY:   begin mul_a = 33'(w.vel_y);     mul_b = {1'b0, dt}; end
      default: begin mul_a = 33'(w.vel_z);     mul_b = {1'b0, dt}; end
    endcase
  end

  assign age_sum   = {1'b0, w.age} + {2'b0, dt};
  assign rem_sh    = {rem, 1'b0};
  assign alpha_new = st.age_ge ? '0 : ALPHA_BITS'(Q_ONE) - ALPHA_BITS'(quo);

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= 66'(mul_a * $signed({1'b0, mul_b}));
    end
    if (cmd.load_work) begin
      w <= rdata;
    end else if (cmd.apply_en) begin
      case (cmd.step)
        ST_GRAV: w.vel_y <= sat32(66'(w.vel_y) - q);
        ST_DRAG: f <= (q >= 66'(Q_ONE)) ? '0 : 32'(66'(Q_ONE) - q);
        ST_VX:   w.vel_x <= q[31:0];
        ST_VY:   w.vel_y <= q[31:0];
        ST_VZ:   w.vel_z <= q[31:0];
        ST_PX:   w.pos_x <= sat32(66'(w.pos_x) + q);
        ST_PY:   w.pos_y <= sat32(66'(w.pos_y) + q);
        default: w.pos_z <= sat32(66'(w.pos_z) + q);
      endcase
    end else if (cmd.age_en) begin
      w.age <= age_sum[32] ? 32'hFFFF_FFFF : age_sum[31:0];
    end
    // restoring division, one quotient bit a cycle
    if (cmd.div_start) begin
      rem <= {1'b0, w.age};
      quo <= '0;
    end else if (cmd.div_step) begin
      if (rem_sh >= {2'b0, w.life}) begin
        rem <= 33'(rem_sh - {2'b0, w.life});
        quo <= {quo[FRAC_BITS-2:0], 1'b1};
      end else begin
        rem <= rem_sh[32:0];
        quo <= {quo[FRAC_BITS-2:0], 1'b0};
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      status <= RES_DONE;
    end else if (cmd.res_set) begin
      status <= cmd.res_code;
    end else if (cmd.rd_capture) begin
      status <= RES_READ;
    end
    if (cmd.res_set) begin
      slot_is_active <= 1'b0;
      out_x          <= '0;
      out_y          <= '0;
      out_z          <= '0;
      out_alpha      <= '0;
      out_kind       <= '0;
    end else if (cmd.rd_capture) begin
      slot_is_active <= active[addr];
      out_x          <= rdata.pos_x;
      out_y          <= rdata.pos_y;
      out_z          <= rdata.pos_z;
      out_alpha      <= 17'(rdata.alpha);
      out_kind       <= rdata.kind;
    end
  end

  assign st.in_cmd = cmd_t'(command);
  assign st.arg_ok = dt < 31'(POOL_SLOTS);
  assign st.act    = active[addr];
  assign st.age_ge = w.age >= w.life;
  assign st.splash = (w.kind == KIND_RAIN) && (w.pos_y <= 32'sd0);

endmodule

`default_nettype wire

@@ hw/rtl/particle_pool_integrator_unit.sv @@
// ----------------------------------------------------------------------------
// particle_pool_integrator_unit
// Pool of particle slots in signed fixed point: spawn, Euler tick, read.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake            | Carries
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_stall  | command, spawn fields, gravity, friction,
//          |                      | argument (tick dt or read slot index)
//  out     | out_valid / out_stall| status, slot_is_active, out_x/y/z,
//          |                      | out_alpha, out_kind
//
//  One request at a time; each gives exactly one result.
//  Spawn: the free search checks one slot a cycle and takes the first free one.
//  Tick: an inactive slot is skipped; an active one makes eight passes through
//  the shared multiplier, then runs the bit-serial alpha divider unless it has
//  aged out, and a rain slot that hits the ground searches for a free slot for
//  its splash.
//  Read: an index out of range skips the slot read. The result waits in
//  registers while out_stall is high.
//  Reset clears every active bit at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module particle_pool_integrator_unit import ppi_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         command,
  input  wire logic signed [31:0] pos_x,
  input  wire logic signed [31:0] pos_y,
  input  wire logic signed [31:0] pos_z,
  input  wire logic signed [31:0] vel_x,
  input  wire logic signed [31:0] vel_y,
  input  wire logic signed [31:0] vel_z,
  input  wire logic [30:0]        lifetime,
  input  wire logic [1:0]         kind,
  input  wire logic signed [31:0] gravity,
  input  wire logic [30:0]        friction,
  input  wire logic [30:0]        argument,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              status,
  output logic                    slot_is_active,
  output logic signed [31:0]      out_x,
  output logic signed [31:0]      out_y,
  output logic signed [31:0]      out_z,
  output logic [16:0]             out_alpha,
  output logic [1:0]              out_kind
);
  ppi_cmd_t  cmd;
  ppi_stat_t st;

  // sequence the request: search, walk, multiply steps, divide, write back
  ppi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  // hold slots, do the arithmetic, hold the result until taken
  ppi_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .command        (command),
    .pos_x          (pos_x),
    .pos_y          (pos_y),
    .pos_z          (pos_z),
    .vel_x          (vel_x),
    .vel_y          (vel_y),
    .vel_z          (vel_z),
    .lifetime       (lifetime),
    .kind           (kind),
    .gravity        (gravity),
    .friction       (friction),
    .argument       (argument),
    .status         (status),
    .slot_is_active (slot_is_active),
    .out_x          (out_x),
    .out_y          (out_y),
    .out_z          (out_z),
    .out_alpha      (out_alpha),
    .out_kind       (out_kind)
  );

endmodule

`default_nettype wire
